// ===== rtl/core/toy_register_machine_core_assert.svh =====
// assertion macros shared by the core modules
// expects i_clk and i_rst_n in the including module
`ifndef TOY_REGISTER_MACHINE_CORE_ASSERT_SVH
`define TOY_REGISTER_MACHINE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define TRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/trm_pkg.sv =====
// shared types, sizes and index helpers for the register machine core
// no dependencies
package trm_pkg;

    localparam int REG_COUNT  = 8;
    localparam int DATA_DEPTH = 256;
    localparam int PROG_DEPTH = 256;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 8;
    localparam int RIDX_W  = $clog2(REG_COUNT);
    localparam int DADDR_W = $clog2(DATA_DEPTH);
    localparam int PC_W    = $clog2(PROG_DEPTH);

    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_LOAD  = 4'd4,
        OP_STORE = 4'd5,
        OP_JMP   = 4'd6,
        OP_JEQ   = 4'd7,
        OP_JGT   = 4'd8,
        OP_JLT   = 4'd9,
        OP_WRITE = 4'd10,
        OP_READ  = 4'd11,
        OP_STOP  = 4'd12
    } t_opcode;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_STOP  = 2'd1,
        ST_BADOP = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_X,
        S_RD_Y,
        S_RD_A,
        S_EXEC,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_SIGN,
        S_DONE
    } t_state;

    function automatic logic [RIDX_W-1:0] ridx(input logic [FIELD_W-1:0] v);
        return RIDX_W'(v % REG_COUNT);
    endfunction

    function automatic logic [DADDR_W-1:0] didx(input logic [FIELD_W-1:0] v);
        return DADDR_W'(v % DATA_DEPTH);
    endfunction

    function automatic logic [PC_W-1:0] pcw(input logic [FIELD_W-1:0] v);
        return PC_W'(v % PROG_DEPTH);
    endfunction

endpackage

// ===== rtl/core/trm_ram.sv =====
// single-port-write, single-port-read ram with per-entry valid bits
// entries never written read as zero; uses no package
module trm_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ===== rtl/core/trm_alu.sv =====
// shared arithmetic unit: add, subtract with borrow, low-word multiply
// depends on trm_pkg
module trm_alu
    import trm_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_res,
    output logic              o_borrow
);

    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] prod;

    assign diff     = {1'b0, i_a} - {1'b0, i_b};
    assign prod     = i_a * i_b;
    assign o_borrow = diff[WORD_W];

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = diff[WORD_W-1:0];
            ALU_MUL: o_res = prod;
            default: o_res = i_a + i_b;
        endcase
    end

endmodule

// ===== rtl/core/toy_register_machine_core.sv =====
// channel   handshake                  payload
// request   i_in_valid / o_in_stall    i_opcode i_op_a i_op_b i_op_c i_read_value
// result    o_res_valid / i_res_stall  o_next_pc o_status o_out_valid o_out_value
//
// one request at a time; the sequencer reads operands one per cycle from the
// register file, then runs the shared alu. div then runs 32 restoring steps
// with sign fixups before and after them. a halted core answers in the cycle
// after the request. the core returns to idle after each delivered result.
// reset (synchronous, active low) clears pc, halt and all storage valid bits.
// a stalled result holds in its output register; requests stall meanwhile.
// depends on trm_pkg, trm_ram, trm_alu and the assertion header
module toy_register_machine_core
    import trm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [3:0]          i_opcode,
    input  logic [FIELD_W-1:0]  i_op_a,
    input  logic [FIELD_W-1:0]  i_op_b,
    input  logic [FIELD_W-1:0]  i_op_c,
    input  logic signed [WORD_W-1:0] i_read_value,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic [7:0]          o_next_pc,
    output logic [1:0]          o_status,
    output logic                o_out_valid,
    output logic signed [WORD_W-1:0] o_out_value
);

`include "toy_register_machine_core_assert.svh"

    t_state r_state, n_state;

    logic [3:0]         r_op;
    logic [FIELD_W-1:0] r_a, r_b, r_c;
    logic [WORD_W-1:0]  r_rv, r_x, r_y;
    logic [WORD_W-1:0]  r_rem, r_quo, r_dvs;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;

    logic [PC_W-1:0]    r_pc, n_pc;
    logic               r_halt, n_halt;
    t_status            r_hcode, n_hcode;

    logic [PC_W-1:0]    r_o_pc;
    logic [1:0]         r_o_status;
    logic               r_o_ov;
    logic [WORD_W-1:0]  r_o_oval;

    // datapath controls
    logic               accept;
    logic               res_load;
    logic               res_ov;
    logic [WORD_W-1:0]  res_oval;
    logic [PC_W-1:0]    pc_inc;
    logic [WORD_W-1:0]  div_sh;

    logic [RIDX_W-1:0]  rf_raddr;
    logic               rf_we;
    logic [RIDX_W-1:0]  rf_waddr;
    logic [WORD_W-1:0]  rf_wdata;
    logic [WORD_W-1:0]  rf_rdata;

    logic               dm_re;
    logic [DADDR_W-1:0] dm_raddr;
    logic               dm_we;
    logic [DADDR_W-1:0] dm_waddr;
    logic [WORD_W-1:0]  dm_wdata;
    logic [WORD_W-1:0]  dm_rdata;

    t_alu_op            alu_op;
    logic [WORD_W-1:0]  alu_a, alu_b, alu_res;
    logic               alu_borrow;

    trm_ram #(.DEPTH(REG_COUNT), .WIDTH(WORD_W)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (1'b1),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    trm_ram #(.DEPTH(DATA_DEPTH), .WIDTH(WORD_W)) u_data (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    trm_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign accept = i_in_valid && !o_in_stall;
    assign pc_inc = r_pc + PC_W'(1);
    assign div_sh = {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_halt ? S_DONE : S_RD_X;
                end
            end
            S_RD_X: n_state = S_RD_Y;
            S_RD_Y: n_state = S_RD_A;
            S_RD_A: n_state = S_EXEC;
            S_EXEC: begin
                if (r_op == OP_DIV && r_y != '0) begin
                    n_state = S_ABS_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ABS_A: n_state = S_ABS_B;
            S_ABS_B: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: n_state = S_DONE;
            S_DONE: begin
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        rf_raddr   = ridx(r_a);
        rf_we      = 1'b0;
        rf_waddr   = ridx(r_a);
        rf_wdata   = alu_res;
        dm_re      = 1'b0;
        dm_raddr   = didx(r_a);
        dm_we      = 1'b0;
        dm_waddr   = didx(r_a);
        dm_wdata   = r_rv;
        alu_op     = ALU_ADD;
        alu_a      = r_x;
        alu_b      = r_y;
        n_pc       = r_pc;
        n_halt     = r_halt;
        n_hcode    = r_hcode;
        res_load   = 1'b0;
        res_ov     = 1'b0;
        res_oval   = '0;
        case (r_state)
            S_IDLE: begin
                // halted core answers straight away
                res_load = i_in_valid && r_halt;
            end
            S_RD_X: begin
                rf_raddr = ridx(r_b);
                dm_re    = 1'b1;
                dm_raddr = (r_op == OP_LOAD) ? didx(r_b) : didx(r_a);
            end
            S_RD_Y: begin
                rf_raddr = ridx(r_c);
            end
            S_RD_A: begin
                rf_raddr = ridx(r_a);
            end
            S_EXEC: begin
                res_load = 1'b1;
                n_pc     = pc_inc;
                case (r_op)
                    OP_ADD: begin
                        alu_op = ALU_ADD;
                        rf_we  = 1'b1;
                    end
                    OP_SUB: begin
                        alu_op = ALU_SUB;
                        rf_we  = 1'b1;
                    end
                    OP_MUL: begin
                        alu_op = ALU_MUL;
                        rf_we  = 1'b1;
                    end
                    OP_DIV: begin
                        if (r_y == '0) begin
                            n_pc    = r_pc;
                            n_halt  = 1'b1;
                            n_hcode = ST_DIVZ;
                        end else begin
                            n_pc     = r_pc;
                            res_load = 1'b0;
                        end
                    end
                    OP_LOAD: begin
                        rf_we    = 1'b1;
                        rf_wdata = dm_rdata;
                    end
                    OP_STORE: begin
                        dm_we    = 1'b1;
                        dm_waddr = didx(r_b);
                        dm_wdata = rf_rdata;
                    end
                    OP_JMP: begin
                        n_pc = pcw(r_a);
                    end
                    OP_JEQ: begin
                        alu_op = ALU_SUB;
                        alu_a  = rf_rdata;
                        alu_b  = r_x;
                        if (alu_res == '0) begin
                            n_pc = pcw(r_c);
                        end
                    end
                    OP_JGT: begin
                        if (!rf_rdata[WORD_W-1] && rf_rdata != '0) begin
                            n_pc = pcw(r_c);
                        end
                    end
                    OP_JLT: begin
                        if (rf_rdata[WORD_W-1]) begin
                            n_pc = pcw(r_c);
                        end
                    end
                    OP_WRITE: begin
                        res_ov   = 1'b1;
                        res_oval = dm_rdata;
                    end
                    OP_READ: begin
                        dm_we = 1'b1;
                    end
                    OP_STOP: begin
                        n_pc    = r_pc;
                        n_halt  = 1'b1;
                        n_hcode = ST_STOP;
                    end
                    default: begin
                        n_pc    = r_pc;
                        n_halt  = 1'b1;
                        n_hcode = ST_BADOP;
                    end
                endcase
            end
            S_ABS_A: begin
                alu_op = ALU_SUB;
                alu_a  = '0;
                alu_b  = r_x;
            end
            S_ABS_B: begin
                alu_op = ALU_SUB;
                alu_a  = '0;
                alu_b  = r_y;
            end
            S_DIV: begin
                // restoring step: trial subtract of the divisor
                alu_op = ALU_SUB;
                alu_a  = div_sh;
                alu_b  = r_dvs;
            end
            S_SIGN: begin
                alu_op   = ALU_SUB;
                alu_a    = '0;
                alu_b    = r_quo;
                rf_we    = 1'b1;
                rf_wdata = r_neg ? alu_res : r_quo;
                n_pc     = pc_inc;
                res_load = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_hcode <= ST_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_hcode <= n_hcode;
            if (r_state == S_ABS_B) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_opcode;
            r_a  <= i_op_a;
            r_b  <= i_op_b;
            r_c  <= i_op_c;
            r_rv <= i_read_value;
        end
        case (r_state)
            S_RD_Y: r_x <= rf_rdata;
            S_RD_A: r_y <= rf_rdata;
            S_EXEC: r_neg <= r_x[WORD_W-1] ^ r_y[WORD_W-1];
            S_ABS_A: begin
                r_quo <= r_x[WORD_W-1] ? alu_res : r_x;
                r_rem <= '0;
            end
            S_ABS_B: r_dvs <= r_y[WORD_W-1] ? alu_res : r_y;
            S_DIV: begin
                r_rem <= alu_borrow ? div_sh : alu_res;
                r_quo <= {r_quo[WORD_W-2:0], ~alu_borrow};
            end
            default: begin
            end
        endcase
        if (res_load) begin
            r_o_pc     <= n_pc;
            r_o_status <= n_halt ? n_hcode : ST_RUN;
            r_o_ov     <= res_ov;
            r_o_oval   <= res_oval;
        end
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_next_pc   = 8'(r_o_pc);
    assign o_status    = r_o_status;
    assign o_out_valid = r_o_ov;
    assign o_out_value = r_o_oval;

    `TRM_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt, "halt flag cleared after halt")
    `TRM_ASSERT_NEXT(a_halt_pc_hold, r_halt, $stable(r_pc), "pc moved while halted")
    `TRM_ASSERT_SAME(a_emit_running, o_res_valid && o_out_valid, o_status == ST_RUN,
        "write emitted with a halt status")
    `TRM_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE, "request accepted but core idle")

endmodule

// ===== tb/sv/toy_register_machine_core_tb.sv =====
// self-checking testbench for toy_register_machine_core: directed and random
// instruction streams, predicted against an in-bench model of the machine state
// depends on trm_pkg and the toy_register_machine_core rtl
module toy_register_machine_core_tb
    import trm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_BAD_LO = 4'd13;
    localparam logic [3:0] OP_BAD_HI = 4'd15;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [7:0]        next_pc;
        logic [1:0]        status;
        logic              out_valid;
        logic [WORD_W-1:0] out_value;
    } t_machine_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [3:0]               i_opcode = '0;
    logic [FIELD_W-1:0]       i_op_a = '0;
    logic [FIELD_W-1:0]       i_op_b = '0;
    logic [FIELD_W-1:0]       i_op_c = '0;
    logic signed [WORD_W-1:0] i_read_value = '0;
    logic                     o_res_valid;
    logic                     i_res_stall = 1'b0;
    logic [7:0]               o_next_pc;
    logic [1:0]               o_status;
    logic                     o_out_valid;
    logic signed [WORD_W-1:0] o_out_value;

    // machine state as the bench expects it
    logic [WORD_W-1:0] model_regs [REG_COUNT];
    logic [WORD_W-1:0] model_mem [DATA_DEPTH];
    logic [7:0]        model_pc;
    logic              model_halted;
    t_status           model_halt_status;

    t_machine_result pending_results [$];

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int writes_seen = 0;
    int cycle_count = 0;
    t_status halt_cause = ST_RUN;

    toy_register_machine_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_op_a       (i_op_a),
        .i_op_b       (i_op_b),
        .i_op_c       (i_op_c),
        .i_read_value (i_read_value),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_next_pc    (o_next_pc),
        .o_status     (o_status),
        .o_out_valid  (o_out_valid),
        .o_out_value  (o_out_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("toy_register_machine_core_tb NOT OK");
            $finish;
        end
    end

    // executes one instruction on the bench state and returns what the core should report
    function automatic t_machine_result exec_instr(input logic [3:0] opc,
                                                   input logic [7:0] a, input logic [7:0] b,
                                                   input logic [7:0] c,
                                                   input logic [WORD_W-1:0] rv);
        t_machine_result   res;
        logic [7:0]        npc;
        logic [WORD_W-1:0] x, y, ra, mag_x, mag_y, quot;
        int                ia, ib, ic, da, db;
        res.out_valid = 1'b0;
        res.out_value = '0;
        if (!model_halted) begin
            ia = int'(a) % REG_COUNT;
            ib = int'(b) % REG_COUNT;
            ic = int'(c) % REG_COUNT;
            da = int'(a) % DATA_DEPTH;
            db = int'(b) % DATA_DEPTH;
            x = model_regs[ib];
            y = model_regs[ic];
            ra = model_regs[ia];
            npc = 8'((int'(model_pc) + 1) % PROG_DEPTH);
            case (opc)
                OP_ADD: model_regs[ia] = x + y;
                OP_SUB: model_regs[ia] = x - y;
                OP_MUL: model_regs[ia] = x * y;
                OP_DIV: begin
                    if (y == '0) begin
                        model_halted = 1'b1;
                        model_halt_status = ST_DIVZ;
                    end else begin
                        // magnitude divide then fix sign; min / -1 wraps back to min
                        mag_x = x[WORD_W-1] ? -x : x;
                        mag_y = y[WORD_W-1] ? -y : y;
                        quot = mag_x / mag_y;
                        model_regs[ia] = (x[WORD_W-1] != y[WORD_W-1]) ? -quot : quot;
                    end
                end
                OP_LOAD:  model_regs[ia] = model_mem[db];
                OP_STORE: model_mem[db] = ra;
                OP_JMP:   npc = 8'(int'(a) % PROG_DEPTH);
                OP_JEQ: begin
                    if (ra == x) npc = 8'(int'(c) % PROG_DEPTH);
                end
                OP_JGT: begin
                    if (!ra[WORD_W-1] && ra != '0) npc = 8'(int'(c) % PROG_DEPTH);
                end
                OP_JLT: begin
                    if (ra[WORD_W-1]) npc = 8'(int'(c) % PROG_DEPTH);
                end
                OP_WRITE: begin
                    res.out_valid = 1'b1;
                    res.out_value = model_mem[da];
                end
                OP_READ: model_mem[da] = rv;
                OP_STOP: begin
                    model_halted = 1'b1;
                    model_halt_status = ST_STOP;
                end
                default: begin
                    model_halted = 1'b1;
                    model_halt_status = ST_BADOP;
                end
            endcase
            if (!model_halted) model_pc = npc;
        end
        res.next_pc = model_pc;
        res.status = model_halted ? model_halt_status : ST_RUN;
        return res;
    endfunction

    task automatic send_request(input logic [3:0] opc, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] c,
                                input logic [WORD_W-1:0] rv);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= opc;
        i_op_a       <= a;
        i_op_b       <= b;
        i_op_c       <= c;
        i_read_value <= rv;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(exec_instr(opc, a, b, c, rv));
        requests_sent++;
    endtask

    function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_checker
        t_machine_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: pc 0x%0h status %0d", o_next_pc, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, o_next_pc);
                check_field("status", want.status, o_status);
                check_field("out_valid", want.out_valid, o_out_valid);
                check_field("out_value", want.out_value, o_out_value);
                results_checked++;
                if (want.out_valid) writes_seen++;
            end
        end
        i_res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return 32'($urandom_range(0, 31)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    // register field that names the given register, with random upper bits
    function automatic logic [7:0] alias_reg(input int idx);
        return 8'(idx + REG_COUNT * $urandom_range(0, 255 / REG_COUNT));
    endfunction

    task automatic test_memory_ops();
        send_request(OP_READ, 8'd0, 8'd9, 8'd3, 32'h7fff_ffff);
        send_request(OP_READ, 8'd1, 8'd0, 8'd0, 32'h8000_0000);
        send_request(OP_READ, 8'd255, 8'd255, 8'd255, 32'hffff_ffff);
        send_request(OP_READ, 8'd2, 8'd0, 8'd0, 32'd7);
        send_request(OP_LOAD, 8'd1, 8'd0, 8'd0, '0);
        send_request(OP_LOAD, 8'd250, 8'd1, 8'd0, '0);     // register index wraps to 2
        send_request(OP_LOAD, 8'd255, 8'd255, 8'd0, '0);
        send_request(OP_LOAD, 8'd3, 8'd2, 8'd0, '0);
        send_request(OP_WRITE, 8'd255, 8'd0, 8'd0, '0);
    endtask

    task automatic test_arith_ops();
        send_request(OP_ADD, 8'd4, 8'd1, 8'd3, '0);         // max + 7 wraps
        send_request(OP_SUB, 8'd5, 8'd2, 8'd3, '0);         // min - 7 wraps
        send_request(OP_MUL, 8'd6, 8'd1, 8'd1, '0);
        send_request(OP_DIV, 8'd12, 8'd2, 8'd7, '0);        // min / -1
        send_request(OP_DIV, 8'd5, 8'd10, 8'd11, '0);       // min / 7 toward zero
        send_request(OP_STORE, 8'd4, 8'd200, 8'd0, '0);
        send_request(OP_WRITE, 8'd200, 8'd0, 8'd0, '0);
        send_request(OP_STORE, 8'd13, 8'd201, 8'd0, '0);
        send_request(OP_WRITE, 8'd201, 8'd0, 8'd0, '0);
    endtask

    task automatic test_jump_ops();
        send_request(OP_JMP, 8'd255, 8'd0, 8'd0, '0);
        send_request(OP_READ, 8'd40, 8'd0, 8'd0, 32'h1234_5678);   // pc wraps past the top
        send_request(OP_JEQ, 8'd1, 8'd9, 8'd77, '0);
        send_request(OP_JEQ, 8'd1, 8'd2, 8'd77, '0);
        send_request(OP_JGT, 8'd1, 8'd0, 8'd100, '0);
        send_request(OP_JGT, 8'd0, 8'd0, 8'd100, '0);      // zero is not positive
        send_request(OP_JLT, 8'd2, 8'd0, 8'd50, '0);
        send_request(OP_JLT, 8'd1, 8'd0, 8'd50, '0);
    endtask

    task automatic test_random_program(input int count);
        logic [3:0] opc;
        logic [7:0] a, b, c;
        int         roll, start, found;
        repeat (count) begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            c = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 15) opc = OP_READ;
            else if (roll < 30) opc = OP_LOAD;
            else if (roll < 38) opc = OP_STORE;
            else if (roll < 46) opc = OP_ADD;
            else if (roll < 54) opc = OP_SUB;
            else if (roll < 62) opc = OP_MUL;
            else if (roll < 72) opc = OP_DIV;
            else if (roll < 77) opc = OP_JMP;
            else if (roll < 84) opc = OP_JEQ;
            else if (roll < 90) opc = OP_JGT;
            else if (roll < 95) opc = OP_JLT;
            else opc = OP_WRITE;
            if (opc == OP_JEQ && $urandom_range(0, 1) == 1)
                b = alias_reg(int'(a) % REG_COUNT);
            // keep the machine running: steer divisors onto a nonzero register
            if (opc == OP_DIV && model_regs[int'(c) % REG_COUNT] == '0) begin
                found = -1;
                start = $urandom_range(0, REG_COUNT - 1);
                for (int i = 0; i < REG_COUNT; i++)
                    if (found < 0 && model_regs[(start + i) % REG_COUNT] != '0)
                        found = (start + i) % REG_COUNT;
                if (found < 0) opc = OP_READ;
                else c = alias_reg(found);
            end
            send_request(opc, a, b, c, pick_word());
        end
    endtask

    task automatic test_halt_behavior();
        int zr;
        halt_cause = t_status'($urandom_range(ST_STOP, ST_DIVZ));
        case (halt_cause)
            ST_STOP:  send_request(OP_STOP, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                                   pick_word());
            ST_BADOP: send_request(4'($urandom_range(OP_BAD_LO, OP_BAD_HI)), 8'($urandom()),
                                   8'($urandom()), 8'($urandom()), pick_word());
            default: begin
                zr = $urandom_range(0, REG_COUNT - 1);
                send_request(OP_SUB, alias_reg(zr), alias_reg(zr), alias_reg(zr), pick_word());
                send_request(OP_DIV, 8'($urandom()), 8'($urandom()), alias_reg(zr),
                             pick_word());
            end
        endcase
        // a halted core must ignore everything that follows
        repeat (8)
            send_request(4'($urandom_range(0, 15)), 8'($urandom()), 8'($urandom()),
                         8'($urandom()), pick_word());
    endtask

    initial begin
        foreach (model_regs[i]) model_regs[i] = '0;
        foreach (model_mem[i]) model_mem[i] = '0;
        model_pc = '0;
        model_halted = 1'b0;
        model_halt_status = ST_RUN;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 30;
        stall_pct = 78;
        test_memory_ops();
        test_arith_ops();
        test_jump_ops();
        test_random_program(640);

        sender_idle_pct = 78;
        stall_pct = 30;
        test_random_program(630);

        sender_idle_pct = 0;
        stall_pct = 0;
        test_random_program(630);
        test_halt_behavior();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d write outputs compared",
                 requests_sent, results_checked, writes_seen);
        $display("all opcodes under three idle/stall mixes, then halt by %s", halt_cause.name());
        if (error_count == 0) begin
            $display("toy_register_machine_core_tb OK");
        end else begin
            $display("toy_register_machine_core_tb NOT OK");
        end
        $finish;
    end

endmodule
